[rtl/core/siph_pkg.sv]
// SipHash-2-4 core package: initialization constants, register indexes,
// sequencer states and the shared state vector type. No dependencies.
`default_nettype none

package siph_pkg;

  localparam logic [63:0] SIP_C0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_C1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_C2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_C3 = 64'h7465646279746573;
  localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned NBYTE_W = 4;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [1:0] ABSORB_ROUNDS_M1 = 2'd1;
  localparam logic [1:0] FINAL_ROUNDS_M1  = 2'd3;

  typedef enum logic {
    REG_KEY_LOW  = 1'b0,
    REG_KEY_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_DONE
  } seq_state_t;

  typedef logic [3:0][63:0] sip_state_t;

  function automatic logic [63:0] tail_mask(input logic [2:0] nbytes);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < nbytes) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/core/siph_round.sv]
// One SipRound over the four-word state, shared by absorb and finalization.
// Depends on siph_pkg for the state type.
`default_nettype none

module siph_round
  import siph_pkg::*;
(
  input  sip_state_t v_in,
  output sip_state_t v_out
);

  logic [63:0] a0, b0, c0, d0;
  logic [63:0] b1, d1, a2, c2;
  logic [63:0] a3, c3, b3, d3;

  always_comb begin
    a0 = v_in[0] + v_in[1];
    c0 = v_in[2] + v_in[3];
    b0 = {v_in[1][50:0], v_in[1][63:51]} ^ a0;
    d0 = {v_in[3][47:0], v_in[3][63:48]} ^ c0;
    a2 = {a0[31:0], a0[63:32]};
    c2 = c0 + b0;
    a3 = a2 + d0;
    b1 = {b0[46:0], b0[63:47]};
    d1 = {d0[42:0], d0[63:43]};
    b3 = b1 ^ c2;
    d3 = d1 ^ a3;
    c3 = {c2[31:0], c2[63:32]};
    v_out[0] = a3;
    v_out[1] = b3;
    v_out[2] = c3;
    v_out[3] = d3;
  end

endmodule

`default_nettype wire

[rtl/core/siphash_keyed_hash_core.sv]
// SipHash-2-4 keyed hash core: key registers, sequencer and state registers.
// Depends on siph_pkg and siph_round.
//
//  channel  | ports                         | payload
//  in       | in_tvalid/in_tready           | in_tdata: message_word, valid_bytes; in_tlast
//  out      | out_tvalid/out_tready         | out_tdata: digest
//  cfg      | cfg_wr_en/cfg_addr/cfg_wdata  | key_low (0), key_high (1)
//
// A word that is not last is taken by its transfer, then runs two rounds of the shared unit.
// A last item adds 4 final rounds and a digest load; 8 bytes add a 2-round length block.
// rst_n is synchronous and clears keys, sequencer, message flag and output valid.
// A held digest stalls only the cycle that would load the next one.
`default_nettype none

module siphash_keyed_hash_core
  import siph_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [63:0] message_word, [67:64] valid_bytes
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [63:0] digest
  input  logic                   cfg_wr_en,
  input  cfg_reg_t               cfg_addr,
  input  logic [WORD_W-1:0]      cfg_wdata
);

  seq_state_t  state_r, state_nxt;
  sip_state_t  v_r, v_nxt, v_rnd, v_base;
  logic [63:0] key_lo_r, key_hi_r;
  logic [63:0] block_r, block_nxt;
  logic [7:0]  len_r, len_nxt, len_base;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        fin_r, fin_nxt;
  logic        pend_r, pend_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [63:0] out_dat_r, out_dat_nxt;
  logic        in_xfer;
  logic [63:0] word;
  logic [NBYTE_W-1:0] nbytes;
  logic        full;

  siph_round u_round (
    .v_in  (v_r),
    .v_out (v_rnd)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;
  assign word       = in_tdata[63:0];
  assign nbytes     = in_tdata[67:64];
  assign full       = !in_tlast || nbytes[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_lo_r <= '0;
      key_hi_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_KEY_LOW:  key_lo_r <= cfg_wdata;
        REG_KEY_HIGH: key_hi_r <= cfg_wdata;
        default:      key_lo_r <= key_lo_r;
      endcase
    end
  end

  always_comb begin
    state_nxt   = state_r;
    v_nxt       = v_r;
    block_nxt   = block_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    fin_nxt     = fin_r;
    pend_nxt    = pend_r;
    in_msg_nxt  = in_msg_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_dat_nxt = out_dat_r;
    if (in_msg_r) begin
      v_base   = v_r;
      len_base = len_r;
    end else begin
      v_base[0] = key_lo_r ^ SIP_C0;
      v_base[1] = key_hi_r ^ SIP_C1;
      v_base[2] = key_lo_r ^ SIP_C2;
      v_base[3] = key_hi_r ^ SIP_C3;
      len_base  = '0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          in_msg_nxt = 1'b1;
          fin_nxt    = in_tlast;
          pend_nxt   = in_tlast && nbytes[3];
          cnt_nxt    = ABSORB_ROUNDS_M1;
          state_nxt  = ST_ROUND;
          if (full) begin
            len_nxt   = len_base + 8'd8;
            block_nxt = word;
          end else begin
            len_nxt   = len_base + {5'd0, nbytes[2:0]};
            block_nxt = {len_nxt, 56'd0} | (word & tail_mask(nbytes[2:0]));
          end
          v_nxt    = v_base;
          v_nxt[3] = v_base[3] ^ block_nxt;
        end
      end
      ST_ROUND: begin
        v_nxt   = v_rnd;
        cnt_nxt = cnt_r - 2'd1;
        if (cnt_r == '0) begin
          v_nxt[0] = v_rnd[0] ^ block_r;
          if (pend_r) begin
            pend_nxt  = 1'b0;
            block_nxt = {len_r, 56'd0};
            v_nxt[3]  = v_rnd[3] ^ block_nxt;
            cnt_nxt   = ABSORB_ROUNDS_M1;
          end else if (fin_r) begin
            v_nxt[2]  = v_rnd[2] ^ FIN_XOR;
            cnt_nxt   = FINAL_ROUNDS_M1;
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FINAL: begin
        v_nxt   = v_rnd;
        cnt_nxt = cnt_r - 2'd1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_dat_nxt = v_r[0] ^ v_r[1] ^ v_r[2] ^ v_r[3];
          in_msg_nxt  = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      in_msg_r  <= 1'b0;
      out_vld_r <= 1'b0;
      fin_r     <= 1'b0;
      pend_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      in_msg_r  <= in_msg_nxt;
      out_vld_r <= out_vld_nxt;
      fin_r     <= fin_nxt;
      pend_r    <= pend_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r       <= v_nxt;
    block_r   <= block_nxt;
    len_r     <= len_nxt;
    out_dat_r <= out_dat_nxt;
  end

  a_word_starts_absorb: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_ROUND) && (cnt_r == ABSORB_ROUNDS_M1) && in_msg_r)
    else $error("transfer did not start two absorb rounds");

  a_last_sets_fin: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> fin_r)
    else $error("last item did not arm finalization");

  a_final_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINAL) |-> fin_r && !pend_r)
    else $error("finalization entered with length block pending");

  a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && (!out_vld_r || out_tready)
      |=> out_vld_r && (state_r == ST_IDLE) && !in_msg_r)
    else $error("digest not loaded at end of message");

  a_no_output_midword: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == ST_DONE)
    else $error("digest appeared outside finalization");

endmodule

`default_nettype wire
